FILE: rtl/obb_pkg.sv
package obb_pkg;

  // CORDIC datapath widths: x/y in Q2.30, angle accumulator in 2^-18 degree
  localparam int XY_W     = 32;
  localparam int Z_W      = 27;
  localparam int MAX_ITER = 24;
  localparam int SIZE_W   = 22;
  localparam int TRIG_W   = 18;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd652032874;

  // angle units are 1/64 degree
  localparam logic [14:0] FULL_TURN    = 15'd23040;
  localparam logic [14:0] QUARTER_TURN = 15'd5760;
  localparam logic [14:0] HALF_TURN    = 15'd11520;
  localparam logic [14:0] THREE_QTR    = 15'd17280;

  localparam logic signed [TRIG_W-1:0] Q16_ONE = 18'sd65536;

  // atan(2^-i) in units of 2^-18 degree
  localparam logic [23:0] ATAN_TAB [MAX_ITER] = '{
    24'd11796480, 24'd6963869, 24'd3679517, 24'd1867780, 24'd937515, 24'd469214,
    24'd234664, 24'd117339, 24'd58671, 24'd29335, 24'd14668, 24'd7334,
    24'd3667, 24'd1833, 24'd917, 24'd458, 24'd229, 24'd115,
    24'd57, 24'd29, 24'd14, 24'd7, 24'd4, 24'd2
  };

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  // request and result codes
  localparam logic REQ_PLACE   = 1'b0;
  localparam logic REQ_QUERY   = 1'b1;
  localparam logic KIND_CORNER = 1'b0;
  localparam logic KIND_POINT  = 1'b1;

  typedef struct packed {
    logic                   v;
    logic [1:0]             quad;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRIG,
    S_MAC,
    S_CORN,
    S_ANS
  } state_t;

endpackage

FILE: rtl/obb_if.sv
// input request channel
interface obb_in_if #(parameter int COORD_BITS = 24) ();
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic [14:0]                  angle_deg;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;

  modport source (output valid, req_type, center_x, center_y, angle_deg, point_x, point_y,
                  input ready);
  modport sink (input valid, req_type, center_x, center_y, angle_deg, point_x, point_y,
                output ready);
endinterface

// result channel
interface obb_out_if #(parameter int COORD_BITS = 24) ();
  logic                         valid;
  logic                         ready;
  logic                         result_kind;
  logic [1:0]                   corner_index;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic                         last;

  modport source (output valid, result_kind, corner_index, out_x, out_y, last, input ready);
  modport sink (input valid, result_kind, corner_index, out_x, out_y, last, output ready);
endinterface

// register write channel
interface obb_cfg_if ();
  logic                                valid;
  logic                                ready;
  logic [obb_pkg::CFG_IDX_W-1:0]       index;
  logic [obb_pkg::SIZE_W-1:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/obb_cordic_cell.sv
// one CORDIC rotation step, registered
module obb_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  obb_pkg::cordic_t cin,
  output obb_pkg::cordic_t cout
);

  logic                            v_r;
  logic [1:0]                      quad_r;
  logic signed [obb_pkg::XY_W-1:0] x_r, y_r;
  logic signed [obb_pkg::Z_W-1:0]  z_r;
  logic signed [obb_pkg::XY_W-1:0] dx, dy;
  logic signed [obb_pkg::Z_W-1:0]  at;

  // floor shifts of the cross terms
  assign dx = $signed(cin.y) >>> IDX;
  assign dy = $signed(cin.x) >>> IDX;
  assign at = {3'b000, obb_pkg::ATAN_TAB[IDX]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= cin.v;
    end
  end

  // rotate toward zero residual angle
  always_ff @(posedge clk) begin
    quad_r <= cin.quad;
    if (!cin.z[obb_pkg::Z_W-1]) begin
      x_r <= cin.x - dx;
      y_r <= cin.y + dy;
      z_r <= cin.z - at;
    end else begin
      x_r <= cin.x + dx;
      y_r <= cin.y - dy;
      z_r <= cin.z + at;
    end
  end

  assign cout = '{v: v_r, quad: quad_r, x: x_r, y: y_r, z: z_r};

endmodule

FILE: rtl/oriented_box_pose_and_closest_point.sv
// Place: the angle runs through the TRIG_ITERATIONS CORDIC cells (trig rounding on the last
// one), then four products on the multiply unit, four corner loads and one output register.
// Query: eight products on the shared multiply-accumulate unit, one answer load, one output
// register. One item in flight; a new request is taken only in idle, and each load waits for
// a free output register. The next is taken while the last result beat waits.
// Synchronous active-low reset: size zero, pose at origin, cos 1.0, sin 0.
module oriented_box_pose_and_closest_point #(
  parameter int COORD_BITS      = 24,
  parameter int TRIG_ITERATIONS = 16
) (
  input logic clk,
  input logic rst_n,
  obb_in_if.sink     in_ch,
  obb_out_if.source  out_ch,
  obb_cfg_if.sink    cfg_ch
);

  localparam int SW = obb_pkg::SIZE_W;
  localparam int TW = obb_pkg::TRIG_W;
  localparam int MW = (COORD_BITS > SW) ? COORD_BITS : SW;
  localparam int BW = MW + 3;
  localparam int PW = BW + TW;
  localparam int AW = MW + 24;
  localparam int CB = COORD_BITS;

  // ---------------------------------------------------------------- helpers
  function automatic logic signed [TW-1:0] trig_round(input logic signed [obb_pkg::XY_W-1:0] v);
    logic signed [obb_pkg::XY_W:0] t;
    logic signed [18:0]            r;
    t = {v[obb_pkg::XY_W-1], v} + 33'sd8192;
    r = t[32:14];
    if (r > 19'sd65536) r = 19'sd65536;
    if (r < -19'sd65536) r = -19'sd65536;
    return r[TW-1:0];
  endfunction

  function automatic logic signed [BW-1:0] clamp_ext(input logic signed [AW-1:0] s,
                                                     input logic [SW-1:0] lim);
    logic signed [AW-1:0] t, l;
    t = s >>> 16;
    l = $signed({{(AW-SW){1'b0}}, lim});
    if (t > l) t = l;
    if (t < -l) t = -l;
    return t[BW-1:0];
  endfunction

  // round from 2^-25 units to Q.8 and saturate
  function automatic logic signed [CB-1:0] finish(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] t, hi, lo;
    t  = (v + AW'(65536)) >>> 17;
    hi = $signed({{(AW-CB+1){1'b0}}, {(CB-1){1'b1}}});
    lo = -hi - AW'(1);
    if (t > hi) t = hi;
    if (t < lo) t = lo;
    return t[CB-1:0];
  endfunction

  // ---------------------------------------------------------------- config
  logic [SW-1:0] w_r, h_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= '0;
      h_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        obb_pkg::REG_WIDTH:  w_r <= cfg_ch.data;
        obb_pkg::REG_HEIGHT: h_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  obb_pkg::state_t state_r, state_nxt;
  logic [3:0]      cnt_r, cnt_nxt;
  logic [1:0]      corner_r, corner_nxt;
  logic            kind_r;
  logic            in_acc, out_free, ld;
  logic            out_v_r;

  assign in_ch.ready = (state_r == obb_pkg::S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_v_r || out_ch.ready;

  obb_pkg::cordic_t st [TRIG_ITERATIONS+1];
  logic [TRIG_ITERATIONS-1:0] cell_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= obb_pkg::S_IDLE;
      cnt_r    <= '0;
      corner_r <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      corner_r <= corner_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    corner_nxt = corner_r;
    ld         = 1'b0;
    unique case (state_r)
      obb_pkg::S_IDLE: begin
        cnt_nxt    = '0;
        corner_nxt = '0;
        if (in_acc) begin
          state_nxt = (in_ch.req_type == obb_pkg::REQ_PLACE) ? obb_pkg::S_TRIG : obb_pkg::S_MAC;
        end
      end
      obb_pkg::S_TRIG: begin
        if (st[TRIG_ITERATIONS].v) state_nxt = obb_pkg::S_MAC;
      end
      obb_pkg::S_MAC: begin
        cnt_nxt = cnt_r + 4'd1;
        if (kind_r == obb_pkg::REQ_PLACE && cnt_r == 4'd4) begin
          state_nxt = obb_pkg::S_CORN;
        end else if (kind_r == obb_pkg::REQ_QUERY && cnt_r == 4'd8) begin
          state_nxt = obb_pkg::S_ANS;
        end
      end
      obb_pkg::S_CORN: begin
        if (out_free) begin
          ld         = 1'b1;
          corner_nxt = corner_r + 2'd1;
          if (corner_r == 2'd3) state_nxt = obb_pkg::S_IDLE;
        end
      end
      obb_pkg::S_ANS: begin
        if (out_free) begin
          ld        = 1'b1;
          state_nxt = obb_pkg::S_IDLE;
        end
      end
      default: state_nxt = obb_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- angle prep
  logic [14:0] ang_w, rest;
  logic [1:0]  quad;

  always_comb begin
    ang_w = (in_ch.angle_deg >= obb_pkg::FULL_TURN) ? in_ch.angle_deg - obb_pkg::FULL_TURN
                                                    : in_ch.angle_deg;
    if (ang_w >= obb_pkg::THREE_QTR) begin
      quad = 2'd3; rest = ang_w - obb_pkg::THREE_QTR;
    end else if (ang_w >= obb_pkg::HALF_TURN) begin
      quad = 2'd2; rest = ang_w - obb_pkg::HALF_TURN;
    end else if (ang_w >= obb_pkg::QUARTER_TURN) begin
      quad = 2'd1; rest = ang_w - obb_pkg::QUARTER_TURN;
    end else begin
      quad = 2'd0; rest = ang_w;
    end
  end

  assign st[0] = '{v: in_acc && (in_ch.req_type == obb_pkg::REQ_PLACE), quad: quad,
                   x: obb_pkg::CORDIC_GAIN, y: '0, z: {rest, 12'b0}};

  // rotation cells
  for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_cell
    obb_cordic_cell #(.IDX(i)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .cin  (st[i]),
      .cout (st[i+1])
    );
    assign cell_v[i] = st[i+1].v;
  end

  logic signed [TW-1:0] c_rnd, s_rnd;
  assign c_rnd = trig_round(st[TRIG_ITERATIONS].x);
  assign s_rnd = trig_round(st[TRIG_ITERATIONS].y);

  // ---------------------------------------------------------------- pose state
  logic signed [CB-1:0] pose_x_r, pose_y_r;
  logic signed [TW-1:0] cos_r, sin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_x_r <= '0;
      pose_y_r <= '0;
      cos_r    <= obb_pkg::Q16_ONE;
      sin_r    <= '0;
    end else begin
      if (in_acc && in_ch.req_type == obb_pkg::REQ_PLACE) begin
        pose_x_r <= in_ch.center_x;
        pose_y_r <= in_ch.center_y;
      end
      if (state_r == obb_pkg::S_TRIG && st[TRIG_ITERATIONS].v) begin
        unique case (st[TRIG_ITERATIONS].quad)
          2'd0: begin cos_r <= c_rnd;  sin_r <= s_rnd;  end
          2'd1: begin cos_r <= -s_rnd; sin_r <= c_rnd;  end
          2'd2: begin cos_r <= -c_rnd; sin_r <= -s_rnd; end
          default: begin cos_r <= s_rnd; sin_r <= -c_rnd; end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) kind_r <= in_ch.req_type;
  end

  // ---------------------------------------------------------------- multiply-accumulate
  logic signed [BW-1:0] dx_r, dy_r, d0_r, d1_r, mx, my;
  logic signed [TW-1:0] op_a;
  logic signed [BW-1:0] op_b;
  logic signed [PW-1:0] prod_r, prod_c;
  logic signed [AW-1:0] acc_r, acc_base, sum;
  logic signed [PW-1:0] xx_r, xy_r, yx_r, yy_r;
  logic signed [AW-1:0] cx_r, cy_r;
  logic signed [CB-1:0] qx_r, qy_r;
  logic [2:0]           j;

  // centre in 2^-9 units
  assign mx = (BW'(pose_x_r) <<< 1) + BW'(w_r);
  assign my = (BW'(pose_y_r) <<< 1) + BW'(h_r);

  // operand schedule
  always_comb begin
    op_a = cos_r;
    op_b = dx_r;
    if (kind_r == obb_pkg::REQ_PLACE) begin
      case (cnt_r[1:0])
        2'd0: begin op_a = cos_r;  op_b = BW'(w_r); end
        2'd1: begin op_a = sin_r;  op_b = BW'(w_r); end
        2'd2: begin op_a = -sin_r; op_b = BW'(h_r); end
        default: begin op_a = cos_r; op_b = BW'(h_r); end
      endcase
    end else begin
      case (cnt_r[2:0])
        3'd0: begin op_a = cos_r;  op_b = dx_r; end
        3'd1: begin op_a = sin_r;  op_b = dy_r; end
        3'd2: begin op_a = cos_r;  op_b = dy_r; end
        3'd3: begin op_a = -sin_r; op_b = dx_r; end
        3'd4: begin op_a = cos_r;  op_b = d0_r; end
        3'd5: begin op_a = -sin_r; op_b = d1_r; end
        3'd6: begin op_a = sin_r;  op_b = d0_r; end
        default: begin op_a = cos_r; op_b = d1_r; end
      endcase
    end
  end

  assign prod_c = PW'(op_a) * PW'(op_b);
  assign j      = 3'(cnt_r - 4'd1);

  always_comb begin
    case (j) inside
      3'd4:    acc_base = AW'(mx) <<< 16;
      3'd6:    acc_base = AW'(my) <<< 16;
      3'd1, 3'd3, 3'd5, 3'd7: acc_base = acc_r;
      default: acc_base = '0;
    endcase
  end

  assign sum = acc_base + AW'(prod_r);

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.req_type == obb_pkg::REQ_QUERY) begin
      dx_r <= (BW'(in_ch.point_x) <<< 1) - mx;
      dy_r <= (BW'(in_ch.point_y) <<< 1) - my;
    end
    prod_r <= prod_c;
    if (state_r == obb_pkg::S_MAC && cnt_r != 4'd0) begin
      if (kind_r == obb_pkg::REQ_PLACE) begin
        case (j[1:0])
          2'd0: begin
            xx_r <= prod_r;
            cx_r <= (AW'(pose_x_r) <<< 17) + (AW'(w_r) <<< 16);
            cy_r <= (AW'(pose_y_r) <<< 17) + (AW'(h_r) <<< 16);
          end
          2'd1: xy_r <= prod_r;
          2'd2: yx_r <= prod_r;
          default: yy_r <= prod_r;
        endcase
      end else begin
        case (j)
          3'd1: d0_r <= clamp_ext(sum, w_r);
          3'd3: d1_r <= clamp_ext(sum, h_r);
          3'd5: qx_r <= finish(sum);
          3'd7: qy_r <= finish(sum);
          default: acc_r <= sum;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- corners and output
  logic signed [AW-1:0] kpx, kpy, tx, ty, ux, uy;
  logic                 sx_pos, sy_pos;

  assign sx_pos = (corner_r == 2'd1) || (corner_r == 2'd2);
  assign sy_pos = corner_r[1];
  assign tx  = sx_pos ? AW'(xx_r) : -AW'(xx_r);
  assign ty  = sx_pos ? AW'(xy_r) : -AW'(xy_r);
  assign ux  = sy_pos ? AW'(yx_r) : -AW'(yx_r);
  assign uy  = sy_pos ? AW'(yy_r) : -AW'(yy_r);
  assign kpx = cx_r + tx + ux;
  assign kpy = cy_r + ty + uy;

  logic                 kind_o_r, last_o_r;
  logic [1:0]           idx_o_r;
  logic signed [CB-1:0] x_o_r, y_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (ld) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      if (state_r == obb_pkg::S_CORN) begin
        kind_o_r <= obb_pkg::KIND_CORNER;
        idx_o_r  <= corner_r;
        x_o_r    <= finish(kpx);
        y_o_r    <= finish(kpy);
        last_o_r <= (corner_r == 2'd3);
      end else begin
        kind_o_r <= obb_pkg::KIND_POINT;
        idx_o_r  <= 2'd0;
        x_o_r    <= qx_r;
        y_o_r    <= qy_r;
        last_o_r <= 1'b1;
      end
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.result_kind  = kind_o_r;
  assign out_ch.corner_index = idx_o_r;
  assign out_ch.out_x        = x_o_r;
  assign out_ch.out_y        = y_o_r;
  assign out_ch.last         = last_o_r;

`ifndef SYNTHESIS
  // only one angle in the cell chain at a time
  a_one_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_v) <= 1) else $error("more than one angle in CORDIC chain");

  // the chain only drains while waiting for it
  a_chain_state: assert property (@(posedge clk) disable iff (!rst_n)
    st[TRIG_ITERATIONS].v |-> state_r == obb_pkg::S_TRIG) else $error("trig result lost");

  // step counter stays in its schedule
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == obb_pkg::S_MAC |-> cnt_r <= 4'd8) else $error("MAC step overrun");

  // the fourth corner beat closes the item
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (ld && state_r == obb_pkg::S_CORN && corner_r == 2'd3) |=> out_ch.valid && out_ch.last)
    else $error("missing last on final corner");
`endif

endmodule
